FILE: sv/xmr_pkg.sv
// Shared types and constants of the XMODEM receiver unit.
// No dependencies; used by every module of the block.
package xmr_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Protocol control bytes
  localparam logic [7:0] C_SOH = 8'h01;
  localparam logic [7:0] C_STX = 8'h02;
  localparam logic [7:0] C_EOT = 8'h04;
  localparam logic [7:0] C_ACK = 8'h06;
  localparam logic [7:0] C_NAK = 8'h15;
  localparam logic [7:0] C_CAN = 8'h18;

  // Completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CANCEL  = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HDR_TO    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_TO   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PURGE_Q   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_NAK_LIMIT = 2'd3;
  localparam int CfgDataW = 16;

  // Block sizes and byte index width
  localparam int IdxW = 11;
  localparam logic [IdxW-1:0] BLK_SMALL = 11'd128;
  localparam logic [IdxW-1:0] BLK_BIG   = 11'd1024;

  // Output word width: 53 bits of fields padded to whole bytes
  localparam int OutW = 56;

  typedef struct packed {
    logic [15:0] header_timeout_ms;
    logic [15:0] byte_timeout_ms;
    logic [15:0] purge_quiet_ms;
    logic [7:0]  nak_limit;
  } xmr_cfg_t;

  typedef struct packed {
    logic [15:0] length;
    logic [1:0]  status;
    logic        done_res;
    logic [7:0]  wr_byte;
    logic [15:0] wr_offset;
    logic        wr_valid;
    logic [7:0]  tx_byte;
    logic        tx_valid;
  } xmr_res_t;

endpackage

FILE: sv/xmr_cfg_regs.sv
// Configuration register file of the XMODEM receiver unit.
// Depends on xmr_pkg for the register indexes and the xmr_cfg_t bundle.
module xmr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [xmr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [xmr_pkg::CfgDataW-1:0] cfg_wdata,
  output xmr_pkg::xmr_cfg_t            cfg
);
  import xmr_pkg::*;

  xmr_cfg_t cfg_r, cfg_nxt;

  // Decode the write onto the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_TO:    cfg_nxt.header_timeout_ms = cfg_wdata;
        CFG_BYTE_TO:   cfg_nxt.byte_timeout_ms   = cfg_wdata;
        CFG_PURGE_Q:   cfg_nxt.purge_quiet_ms    = cfg_wdata;
        CFG_NAK_LIMIT: cfg_nxt.nak_limit         = cfg_wdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_timeout_ms <= 16'd200;
      cfg_r.byte_timeout_ms   <= 16'd100;
      cfg_r.purge_quiet_ms    <= 16'd100;
      cfg_r.nak_limit         <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/xmr_core.sv
// Protocol state machine of the XMODEM receiver unit: state registers and the
// per-word update. Depends on xmr_pkg for codes and the cfg/result bundles.
module xmr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [1:0]        req_type,
  input  logic [7:0]        rx_byte,
  input  xmr_pkg::xmr_cfg_t cfg,
  output xmr_pkg::xmr_res_t res
);
  import xmr_pkg::*;

  localparam logic [2:0] PH_PURGE  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_BLKNUM = 3'd2;
  localparam logic [2:0] PH_COMP   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CKSUM  = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;
  localparam logic [2:0] PH_IDLE   = 3'd7;

  logic [2:0]      phase_r, phase_nxt;
  logic [15:0]     tick_r, tick_nxt;
  logic [7:0]      naks_r, naks_nxt;
  logic [7:0]      exp_blk_r, exp_blk_nxt;
  logic            big_r, big_nxt;
  logic [7:0]      got_blk_r, got_blk_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [15:0]     len_r, len_nxt;

  logic [IdxW-1:0] blk_size;
  logic [IdxW-1:0] idx_inc;
  logic [15:0]     tick_inc;
  logic [15:0]     limit;
  logic [7:0]      prev_blk;

  assign blk_size = big_r ? BLK_BIG : BLK_SMALL;
  assign idx_inc  = idx_r + IdxW'(1);
  assign tick_inc = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
  assign prev_blk = exp_blk_r - 8'd1;

  // Pick the timeout that applies to the current phase
  always_comb begin
    case (phase_r)
      PH_PURGE:  limit = cfg.purge_quiet_ms;
      PH_HEADER: limit = cfg.header_timeout_ms;
      default:   limit = cfg.byte_timeout_ms;
    endcase
  end

  // Work out the next state and the result of the word at the head
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    naks_nxt    = naks_r;
    exp_blk_nxt = exp_blk_r;
    big_nxt     = big_r;
    got_blk_nxt = got_blk_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    res         = '0;

    if (req_type == REQ_START) begin
      phase_nxt   = PH_PURGE;
      tick_nxt    = '0;
      naks_nxt    = '0;
      exp_blk_nxt = 8'd1;
      big_nxt     = 1'b0;
      got_blk_nxt = '0;
      idx_nxt     = '0;
      sum_nxt     = '0;
      len_nxt     = '0;
    end else if (req_type == REQ_TICK && phase_r != PH_IDLE) begin
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        tick_nxt = '0;
        if (phase_r == PH_PURGE) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = C_NAK;
          if (naks_r >= cfg.nak_limit) begin
            res.done_res = 1'b1;
            res.status   = ST_TIMEOUT;
            phase_nxt    = PH_IDLE;
          end else begin
            if (naks_r != 8'hFF) naks_nxt = naks_r + 8'd1;
            phase_nxt = PH_HEADER;
          end
        end else begin
          phase_nxt = PH_PURGE;
        end
      end
    end else if (req_type == REQ_BYTE && phase_r != PH_IDLE) begin
      tick_nxt = '0;
      case (phase_r)
        PH_HEADER: begin
          if (rx_byte == C_SOH || rx_byte == C_STX) begin
            big_nxt   = (rx_byte == C_STX);
            phase_nxt = PH_BLKNUM;
          end else if (rx_byte == C_EOT) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = C_ACK;
            res.done_res = 1'b1;
            res.length   = len_r;
            phase_nxt    = PH_IDLE;
          end else if (rx_byte == C_CAN) begin
            res.done_res = 1'b1;
            res.status   = ST_CANCEL;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt = PH_PURGE;
          end
        end
        PH_BLKNUM: begin
          got_blk_nxt = rx_byte;
          phase_nxt   = PH_COMP;
        end
        PH_COMP: begin
          idx_nxt = '0;
          sum_nxt = '0;
          if (got_blk_r == exp_blk_r && rx_byte == ~exp_blk_r)
            phase_nxt = PH_DATA;
          else if (got_blk_r == prev_blk && rx_byte == ~prev_blk)
            phase_nxt = PH_SKIP;
          else
            phase_nxt = PH_PURGE;
        end
        PH_DATA: begin
          res.wr_valid  = 1'b1;
          res.wr_offset = len_r + 16'(idx_r);
          res.wr_byte   = rx_byte;
          sum_nxt       = sum_r + rx_byte;
          idx_nxt       = idx_inc;
          if (idx_inc >= blk_size) phase_nxt = PH_CKSUM;
        end
        PH_CKSUM: begin
          if (rx_byte == sum_r) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = C_ACK;
            exp_blk_nxt  = exp_blk_r + 8'd1;
            len_nxt      = len_r + 16'(blk_size);
            phase_nxt    = PH_HEADER;
          end else begin
            phase_nxt = PH_PURGE;
          end
        end
        PH_SKIP: begin
          idx_nxt = idx_inc;
          if (idx_inc >= blk_size + IdxW'(1)) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = C_ACK;
            naks_nxt     = '0;
            phase_nxt    = PH_HEADER;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit the update when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PURGE;
      tick_r    <= '0;
      naks_r    <= '0;
      exp_blk_r <= 8'd1;
      big_r     <= 1'b0;
      got_blk_r <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
      len_r     <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      naks_r    <= naks_nxt;
      exp_blk_r <= exp_blk_nxt;
      big_r     <= big_nxt;
      got_blk_r <= got_blk_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

FILE: sv/xmodem_receiver_unit.sv
// XMODEM receiver unit (checksum, 128/1024-byte blocks). Each input word is a
// received byte, a millisecond tick or a start request, and produces exactly one
// result word carrying any ACK/NAK reply, any data write and the completion
// status. A word passes an input register, the state-machine update and a
// result register: one word per cycle sustained while out_tready is high. While a
// result waits, the input register holds its word; in_tready is high while that
// register is empty or its word moves to the result register. Configuration
// must be written through the cfg_ port while no word is in flight; the block
// does not enforce this. Depends on xmr_pkg, xmr_cfg_regs and xmr_core.
module xmodem_receiver_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic [1:0]                   in_tuser,   // [1:0] req_type
  // Result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] wr_valid, [25:10] wr_offset,
  // [33:26] wr_byte, [34] done_res, [36:35] status, [52:37] length, [55:53] zero
  output logic [xmr_pkg::OutW-1:0]     out_tdata,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [xmr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [xmr_pkg::CfgDataW-1:0] cfg_wdata
);
  import xmr_pkg::*;

  xmr_cfg_t cfg;
  xmr_res_t res;
  xmr_res_t res_r;

  logic       in_vld_r;
  logic [1:0] in_req_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       res_load;
  logic       in_load;

  // Result register frees up when empty or being taken this cycle
  assign res_load  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || res_load;
  assign in_load   = in_tvalid && in_tready;

  xmr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  xmr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (res_load),
    .req_type (in_req_r),
    .rx_byte  (in_byte_r),
    .cfg      (cfg),
    .res      (res)
  );

  // Input register: hold the word until the core consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_req_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // Result register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OutW - $bits(xmr_res_t))'(0), res_r};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for xmodem_receiver_unit: directed and random XMODEM line
// traffic, a cycle-free prediction of every result word and field-by-field checking.
// Depends on xmr_pkg and the RTL of the unit.
module testbench;
  import xmr_pkg::*;

  // Item kind that the unit ignores
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    PH_PURGE, PH_HEADER, PH_BLKNUM, PH_COMP, PH_DATA, PH_CKSUM, PH_SKIP, PH_IDLE
  } rx_phase_e;

  typedef enum int {F_NONE, F_SUM, F_NUM, F_COMP, F_STALL} blk_fault_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx;
  } line_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [7:0] rx_byte
  logic [1:0]           in_tuser = '0;   // [1:0] req_type
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] wr_valid, [25:10] wr_offset,
  // [33:26] wr_byte, [34] done_res, [36:35] status, [52:37] length, [55:53] zero
  logic [OutW-1:0]      out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  xmodem_receiver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  line_word_t line_q[$];
  xmr_res_t   reply_q[$];
  int         errors = 0;
  int         words_made = 0;
  bit         in_fired = 1'b0;
  bit         calm = 1'b0;
  bit         stx_pending = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;
  logic [7:0] gen_blk;

  // Register copies for prediction
  logic [15:0] cfg_hdr_to = 16'd200;
  logic [15:0] cfg_byte_to = 16'd100;
  logic [15:0] cfg_purge_q = 16'd100;
  logic [7:0]  cfg_nak_limit = 8'd10;

  // Receiver state for prediction
  rx_phase_e   rx_phase;
  logic [15:0] quiet_ticks;
  logic [7:0]  nak_tally;
  logic [7:0]  want_blk;
  logic        blk_big;
  logic [7:0]  seen_blk;
  logic [10:0] data_pos;
  logic [7:0]  data_sum;
  logic [15:0] saved_len;

  function automatic void restart_download();
    rx_phase = PH_PURGE;
    quiet_ticks = '0;
    nak_tally = '0;
    want_blk = 8'd1;
    blk_big = 1'b0;
    seen_blk = '0;
    data_pos = '0;
    data_sum = '0;
    saved_len = '0;
  endfunction

  function automatic void enter_phase(rx_phase_e p);
    rx_phase = p;
    quiet_ticks = '0;
  endfunction

  // Advance the receiver state by one line word and return the result word it causes
  function automatic xmr_res_t predict_reply(logic [1:0] kind, logic [7:0] b);
    xmr_res_t    r;
    logic [15:0] limit;
    logic [10:0] size;
    logic [7:0]  prev;
    r = '0;
    size = blk_big ? BLK_BIG : BLK_SMALL;
    prev = want_blk - 8'd1;
    if (kind == REQ_START) begin
      restart_download();
    end else if (kind == REQ_TICK && rx_phase != PH_IDLE) begin
      if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
      case (rx_phase)
        PH_PURGE:  limit = cfg_purge_q;
        PH_HEADER: limit = cfg_hdr_to;
        default:   limit = cfg_byte_to;
      endcase
      if (quiet_ticks >= limit) begin
        if (rx_phase == PH_PURGE) begin
          r.tx_valid = 1'b1;
          r.tx_byte = C_NAK;
          if (nak_tally >= cfg_nak_limit) begin
            r.done_res = 1'b1;
            r.status = ST_TIMEOUT;
            enter_phase(PH_IDLE);
          end else begin
            if (nak_tally != 8'hFF) nak_tally = nak_tally + 8'd1;
            enter_phase(PH_HEADER);
          end
        end else begin
          enter_phase(PH_PURGE);
        end
      end
    end else if (kind == REQ_BYTE && rx_phase != PH_IDLE) begin
      quiet_ticks = '0;
      case (rx_phase)
        PH_HEADER: begin
          if (b == C_SOH || b == C_STX) begin
            blk_big = (b == C_STX);
            enter_phase(PH_BLKNUM);
          end else if (b == C_EOT) begin
            r.tx_valid = 1'b1;
            r.tx_byte = C_ACK;
            r.done_res = 1'b1;
            r.length = saved_len;
            enter_phase(PH_IDLE);
          end else if (b == C_CAN) begin
            r.done_res = 1'b1;
            r.status = ST_CANCEL;
            enter_phase(PH_IDLE);
          end else begin
            enter_phase(PH_PURGE);
          end
        end
        PH_BLKNUM: begin
          seen_blk = b;
          enter_phase(PH_COMP);
        end
        PH_COMP: begin
          data_pos = '0;
          data_sum = '0;
          if (seen_blk == want_blk && b == ~want_blk) enter_phase(PH_DATA);
          else if (seen_blk == prev && b == ~prev) enter_phase(PH_SKIP);
          else enter_phase(PH_PURGE);
        end
        PH_DATA: begin
          r.wr_valid = 1'b1;
          r.wr_offset = saved_len + {5'd0, data_pos};
          r.wr_byte = b;
          data_sum = data_sum + b;
          data_pos = data_pos + 11'd1;
          if (data_pos >= size) enter_phase(PH_CKSUM);
        end
        PH_CKSUM: begin
          if (b == data_sum) begin
            r.tx_valid = 1'b1;
            r.tx_byte = C_ACK;
            want_blk = want_blk + 8'd1;
            saved_len = saved_len + {5'd0, size};
            enter_phase(PH_HEADER);
          end else begin
            enter_phase(PH_PURGE);
          end
        end
        PH_SKIP: begin
          data_pos = data_pos + 11'd1;
          if (data_pos >= size + 11'd1) begin
            r.tx_valid = 1'b1;
            r.tx_byte = C_ACK;
            nak_tally = '0;
            enter_phase(PH_HEADER);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Mostly no pause, some short ones and a few long ones
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the next line word at the falling edge
  always @(negedge clk) begin
    line_word_t w;
    if (rst_n && (!in_tvalid || in_fired)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (line_q.size() != 0) begin
        w = line_q.pop_front();
        in_tuser <= w.kind;
        in_tdata <= w.rx;
        in_tvalid <= 1'b1;
        send_gap = pick_pause();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_pause();
    end
  end

  task automatic report_miss(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    if (errors <= 100)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Predict on each accepted line word, check each accepted result word
  always @(posedge clk) begin
    xmr_res_t got;
    xmr_res_t want;
    in_fired = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_fired = 1'b1;
        reply_q.push_back(predict_reply(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[52:0];
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 100)
            $display("%0t ns: result with none expected, actual %0h", $time, out_tdata);
        end else begin
          want = reply_q.pop_front();
          if (got.tx_valid !== want.tx_valid) report_miss("tx_valid", want.tx_valid, got.tx_valid);
          if (got.tx_byte !== want.tx_byte) report_miss("tx_byte", want.tx_byte, got.tx_byte);
          if (got.wr_valid !== want.wr_valid) report_miss("wr_valid", want.wr_valid, got.wr_valid);
          if (got.wr_offset !== want.wr_offset)
            report_miss("wr_offset", want.wr_offset, got.wr_offset);
          if (got.wr_byte !== want.wr_byte) report_miss("wr_byte", want.wr_byte, got.wr_byte);
          if (got.done_res !== want.done_res) report_miss("done_res", want.done_res, got.done_res);
          if (got.status !== want.status) report_miss("status", want.status, got.status);
          if (got.length !== want.length) report_miss("length", want.length, got.length);
          if (out_tdata[55:53] !== 3'd0) report_miss("padding", 16'd0, out_tdata[55:53]);
        end
      end
    end
  end

  task automatic push_word(logic [1:0] kind, logic [7:0] b);
    line_word_t w;
    w.kind = kind;
    w.rx = b;
    line_q.push_back(w);
    words_made++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_word(REQ_TICK, 8'($urandom));
  endtask

  // Occasional ticks between block bytes, short of the byte timeout
  task automatic lull();
    int top;
    top = int'(cfg_byte_to) - 1;
    if (top > 3) top = 3;
    if (top >= 1 && $urandom_range(0, 7) == 0) push_ticks($urandom_range(1, top));
  endtask

  // Queue one block, well formed or with one fault
  task automatic push_block(logic [7:0] num, bit big, blk_fault_e fault);
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] num_b;
    logic [7:0] comp_b;
    int size;
    int stop;
    size = big ? 1024 : 128;
    num_b = num;
    comp_b = ~num;
    if (fault == F_NUM) num_b = num ^ 8'($urandom_range(1, 255));
    if (fault == F_COMP) comp_b = comp_b ^ 8'($urandom_range(1, 255));
    stop = (fault == F_NUM || fault == F_COMP || fault == F_STALL) ?
           $urandom_range(0, 20) : size;
    push_word(REQ_BYTE, big ? C_STX : C_SOH);
    lull();
    push_word(REQ_BYTE, num_b);
    lull();
    push_word(REQ_BYTE, comp_b);
    sum = '0;
    for (int i = 0; i < stop; i++) begin
      lull();
      d = 8'($urandom);
      sum = sum + d;
      push_word(REQ_BYTE, d);
    end
    if (fault == F_STALL) begin
      push_ticks(int'(cfg_byte_to));
    end else if (stop == size) begin
      lull();
      push_word(REQ_BYTE, (fault == F_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  // One download: start, purge, a run of blocks with faults and repeats, then the end
  task automatic run_session(int events);
    int pick;
    int top;
    gen_blk = 8'd1;
    push_word(REQ_START, 8'($urandom));
    push_ticks(int'(cfg_purge_q));
    repeat (events) begin
      top = int'(cfg_hdr_to) - 1;
      if (top > 3) top = 3;
      if (top >= 1 && $urandom_range(0, 3) == 0) push_ticks($urandom_range(1, top));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_block(gen_blk, stx_pending, F_NONE);
        stx_pending = 1'b0;
        gen_blk = gen_blk + 8'd1;
      end else if (pick < 65) begin
        push_block(gen_blk - 8'd1, 1'b0, F_NONE);
      end else begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: push_block(gen_blk, 1'b0, F_SUM);
          1: push_block(gen_blk, $urandom_range(0, 1), F_NUM);
          2: push_block(gen_blk, $urandom_range(0, 1), F_COMP);
          3: begin
            if (cfg_byte_to <= 16) push_block(gen_blk, $urandom_range(0, 1), F_STALL);
            else push_block(gen_blk, 1'b0, F_SUM);
          end
          4: push_word(REQ_BYTE, 8'($urandom_range(5, 255)));
          default: begin
            if (cfg_hdr_to <= 16) push_ticks(int'(cfg_hdr_to));
            else push_word(REQ_BYTE, 8'($urandom_range(5, 255)));
          end
        endcase
        push_ticks(int'(cfg_purge_q));
      end
    end
    push_word(REQ_BYTE, ($urandom_range(0, 4) == 0) ? C_CAN : C_EOT);
    push_word(REQ_BYTE, 8'($urandom));
    push_word(REQ_TICK, 8'($urandom));
  endtask

  // Loose traffic of every kind, control bytes among it
  task automatic push_noise(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) push_word(REQ_START, 8'($urandom));
      else if (pick == 1) push_word(REQ_IGNORED, 8'($urandom));
      else if (pick < 9) push_word(REQ_TICK, 8'($urandom));
      else if (pick < 13) push_word(REQ_BYTE, 8'($urandom_range(0, 24)));
      else push_word(REQ_BYTE, 8'($urandom));
    end
  endtask

  // Wait until nothing is queued or in flight, then let the pipeline settle
  task automatic drain();
    while (line_q.size() != 0 || reply_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] hdr, logic [15:0] byte_to, logic [15:0] purge,
                                logic [7:0] naks);
    drain();
    calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HDR_TO;
    cfg_wdata <= hdr;
    cfg_hdr_to = hdr;
    @(negedge clk);
    cfg_index <= CFG_BYTE_TO;
    cfg_wdata <= byte_to;
    cfg_byte_to = byte_to;
    @(negedge clk);
    cfg_index <= CFG_PURGE_Q;
    cfg_wdata <= purge;
    cfg_purge_q = purge;
    @(negedge clk);
    cfg_index <= CFG_NAK_LIMIT;
    cfg_wdata <= {8'd0, naks};
    cfg_nak_limit = naks;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    restart_download();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values of the registers
    push_word(REQ_IGNORED, 8'h00);
    push_word(REQ_TICK, 8'hFF);
    push_word(REQ_BYTE, 8'h5A);

    // Directed: end of file, cancel, bad header, NAK limit, header and byte timeouts
    apply_settings(16'd3, 16'd2, 16'd1, 8'd1);
    push_word(REQ_IGNORED, 8'hFF);
    push_word(REQ_START, 8'h00);
    push_word(REQ_BYTE, 8'hA5);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_BYTE, C_EOT);
    push_word(REQ_BYTE, C_SOH);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_START, 8'hFF);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_BYTE, C_CAN);
    push_word(REQ_START, 8'h00);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_BYTE, 8'h7E);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_START, 8'h00);
    push_word(REQ_TICK, 8'h00);
    push_ticks(3);
    push_word(REQ_START, 8'h00);
    push_word(REQ_TICK, 8'h00);
    push_word(REQ_BYTE, C_SOH);
    push_word(REQ_BYTE, 8'h01);
    push_word(REQ_BYTE, 8'hFE);
    push_ticks(2);

    // Random downloads across several register settings
    stx_pending = 1'b1;
    while (words_made < 1500) begin
      apply_settings(16'd0, 16'd0, 16'd0, 8'd0);
      push_noise(20);
      apply_settings(16'd1, 16'd1, 16'hFFFF, 8'd3);
      push_noise(30);
      apply_settings(16'd2, 16'd1, 16'd3, 8'd2);
      run_session($urandom_range(3, 5));
      if (words_made < 1500) begin
        apply_settings(16'd4, 16'd3, 16'd2, 8'd10);
        run_session($urandom_range(2, 4));
      end
      if (words_made < 1500) begin
        apply_settings(16'hFFFF, 16'hFFFF, 16'd1, 8'hFF);
        run_session($urandom_range(2, 3));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
